### src/epsc_pkg.sv
`timescale 1ns / 1ps

package epsc_pkg;

    typedef enum logic [2:0] {
        ST_UNKNOWN = 3'd0,
        ST_A       = 3'd1,
        ST_B       = 3'd2,
        ST_C       = 3'd3,
        ST_D       = 3'd4,
        ST_DIODE   = 3'd5,
        ST_GFAULT  = 3'd6
    } state_t;

    typedef enum logic [1:0] {
        MODE_P12 = 2'd0,
        MODE_PWM = 2'd1,
        MODE_N12 = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_THRESH_A_B     = 3'd0,
        REG_THRESH_B_C     = 3'd1,
        REG_THRESH_C_D     = 3'd2,
        REG_THRESH_D_FLOOR = 3'd3,
        REG_THRESH_DIODE   = 3'd4,
        REG_CHECK_ENABLES  = 3'd5,
        REG_CAPACITY_AMPS  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [9:0] thresh_a_b;
        logic [9:0] thresh_b_c;
        logic [9:0] thresh_c_d;
        logic [9:0] thresh_d_floor;
        logic [9:0] thresh_diode;
        logic [1:0] check_enables;
        logic [6:0] capacity_amps;
    } cfg_t;

    localparam logic [9:0]  THRESH_A_B_RST     = 10'd875;
    localparam logic [9:0]  THRESH_B_C_RST     = 10'd780;
    localparam logic [9:0]  THRESH_C_D_RST     = 10'd690;
    localparam logic [9:0]  THRESH_D_FLOOR_RST = 10'd0;
    localparam logic [9:0]  THRESH_DIODE_RST   = 10'd260;
    localparam logic [1:0]  CHECK_ENABLES_RST  = 2'd3;
    localparam logic [6:0]  CAPACITY_AMPS_RST  = 7'd16;

    localparam logic [10:0] STEADY_MARGIN  = 11'd10;
    localparam logic [9:0]  GFAULT_LOW_MAX = 10'd500;
    localparam logic [6:0]  AMPS_MIN       = 7'd6;
    localparam logic [6:0]  AMPS_MAX       = 7'd80;
    localparam logic [31:0] DEBOUNCE_A_MS  = 32'd25;
    localparam logic [31:0] DEBOUNCE_MS    = 32'd250;

endpackage

### src/epsc_classify.sv
`timescale 1ns / 1ps

module epsc_classify (
    input  epsc_pkg::cfg_t   cfg,
    input  logic [9:0]       pilot_low,
    input  logic [9:0]       pilot_high,
    output epsc_pkg::state_t raw_state
);

    logic steady;

    assign steady = ({1'b0, pilot_high} < ({1'b0, pilot_low} + epsc_pkg::STEADY_MARGIN));

    always_comb
    begin
        raw_state = epsc_pkg::ST_UNKNOWN;
        if (steady)
        begin
            if (pilot_low < epsc_pkg::GFAULT_LOW_MAX)
            begin
                raw_state = epsc_pkg::ST_GFAULT;
            end
            else if (pilot_high >= cfg.thresh_a_b)
            begin
                raw_state = epsc_pkg::ST_A;
            end
        end
        else if (cfg.check_enables[0] && (pilot_low >= cfg.thresh_diode))
        begin
            raw_state = epsc_pkg::ST_DIODE;
        end
        else if (pilot_high >= cfg.thresh_a_b)
        begin
            raw_state = epsc_pkg::ST_A;
        end
        else if (pilot_high >= cfg.thresh_b_c)
        begin
            raw_state = epsc_pkg::ST_B;
        end
        else if (pilot_high >= cfg.thresh_c_d)
        begin
            raw_state = epsc_pkg::ST_C;
        end
        else if (pilot_high > cfg.thresh_d_floor)
        begin
            raw_state = cfg.check_enables[1] ? epsc_pkg::ST_D : epsc_pkg::ST_UNKNOWN;
        end
    end

endmodule

### src/ev_pilot_state_classifier.sv
`timescale 1ns / 1ps

// pilot state classifier with debounce
// input channel: in_valid / in_stall with pilot_low, pilot_high, now_ms; one beat is one
//   pilot sample, taken when in_valid is high and in_stall is low
// output channel: out_valid / out_stall with evse_state, state_changed, relay_on,
//   pilot_mode, pwm_amps, fault_flag; exactly one result beat per sample, in order
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high, indexes above 6 are dropped; write only while no sample is in flight
// a taken sample waits in the input register until its result loads the result register
// throughput: one sample per cycle unless out_stall holds; the debounce state and result
//   register load together, so successive samples see each other's effect at once
// stall: while out_stall holds a result, one more sample can sit in the input register;
//   in_stall rises only when both the input and result registers are full
// reset: rst_n low clears both registers, sets the debounced state to A with relay open,
//   +12V pilot, zero amps and no fault, and loads the config registers with their defaults
module ev_pilot_state_classifier (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  pilot_low,
    input  logic [9:0]  pilot_high,
    input  logic [31:0] now_ms,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  evse_state,
    output logic        state_changed,
    output logic        relay_on,
    output logic [1:0]  pilot_mode,
    output logic [6:0]  pwm_amps,
    output logic        fault_flag,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    epsc_pkg::cfg_t   cfg_reg;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [9:0]       s1_low_reg;
    logic [9:0]       s1_high_reg;
    logic [31:0]      s1_now_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    epsc_pkg::state_t cur_state_reg;
    epsc_pkg::state_t cur_state_next;
    epsc_pkg::state_t cand_state_reg;
    epsc_pkg::state_t cand_state_next;
    logic [31:0]      cand_start_reg;
    logic [31:0]      cand_start_next;
    logic             changed_reg;
    logic             changed_next;
    logic             relay_reg;
    logic             relay_next;
    epsc_pkg::mode_t  mode_reg;
    epsc_pkg::mode_t  mode_next;
    logic [6:0]       amps_reg;
    logic [6:0]       amps_next;
    logic             fault_reg;
    logic             fault_next;

    epsc_pkg::state_t raw_state;
    logic             in_take;
    logic             advance;
    logic [31:0]      elapsed;
    logic [31:0]      need_ms;
    logic [6:0]       clamped_amps;

    epsc_classify u_classify (
        .cfg        (cfg_reg),
        .pilot_low  (s1_low_reg),
        .pilot_high (s1_high_reg),
        .raw_state  (raw_state)
    );

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign elapsed = s1_now_reg - cand_start_reg;
    assign need_ms = (raw_state == epsc_pkg::ST_A) ? epsc_pkg::DEBOUNCE_A_MS
                                                   : epsc_pkg::DEBOUNCE_MS;

    always_comb
    begin
        if (cfg_reg.capacity_amps < epsc_pkg::AMPS_MIN)
        begin
            clamped_amps = epsc_pkg::AMPS_MIN;
        end
        else if (cfg_reg.capacity_amps > epsc_pkg::AMPS_MAX)
        begin
            clamped_amps = epsc_pkg::AMPS_MAX;
        end
        else
        begin
            clamped_amps = cfg_reg.capacity_amps;
        end
    end

    // handshake bookkeeping
    always_comb
    begin
        s1_valid_next = in_take || (s1_valid_reg && !advance);
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // debounce and transition actions
    always_comb
    begin
        cur_state_next  = cur_state_reg;
        cand_state_next = cand_state_reg;
        cand_start_next = cand_start_reg;
        changed_next    = changed_reg;
        relay_next      = relay_reg;
        mode_next       = mode_reg;
        amps_next       = amps_reg;
        fault_next      = fault_reg;
        if (advance)
        begin
            if (raw_state != cur_state_reg)
            begin
                if (raw_state != cand_state_reg)
                begin
                    cand_start_next = s1_now_reg;
                end
                else if (elapsed >= need_ms)
                begin
                    cur_state_next = raw_state;
                end
            end
            cand_state_next = raw_state;
            changed_next    = (cur_state_next != cur_state_reg);
            if (changed_next)
            begin
                case (cur_state_next)
                    epsc_pkg::ST_A:
                    begin
                        relay_next = 1'b0;
                        fault_next = 1'b0;
                        mode_next  = epsc_pkg::MODE_P12;
                    end
                    epsc_pkg::ST_B:
                    begin
                        relay_next = 1'b0;
                        fault_next = 1'b0;
                        mode_next  = epsc_pkg::MODE_PWM;
                        amps_next  = clamped_amps;
                    end
                    epsc_pkg::ST_C:
                    begin
                        relay_next = 1'b1;
                        fault_next = 1'b0;
                        mode_next  = epsc_pkg::MODE_PWM;
                        amps_next  = clamped_amps;
                    end
                    epsc_pkg::ST_D:
                    begin
                        relay_next = 1'b0;
                        fault_next = 1'b1;
                        mode_next  = epsc_pkg::MODE_P12;
                    end
                    default:
                    begin
                        relay_next = 1'b0;
                        fault_next = 1'b1;
                        mode_next  = epsc_pkg::MODE_N12;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_state_reg  <= epsc_pkg::ST_A;
            cand_state_reg <= epsc_pkg::ST_UNKNOWN;
            cand_start_reg <= 32'd0;
            changed_reg    <= 1'b0;
            relay_reg      <= 1'b0;
            mode_reg       <= epsc_pkg::MODE_P12;
            amps_reg       <= 7'd0;
            fault_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            cur_state_reg  <= cur_state_next;
            cand_state_reg <= cand_state_next;
            cand_start_reg <= cand_start_next;
            changed_reg    <= changed_next;
            relay_reg      <= relay_next;
            mode_reg       <= mode_next;
            amps_reg       <= amps_next;
            fault_reg      <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_low_reg  <= pilot_low;
            s1_high_reg <= pilot_high;
            s1_now_reg  <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_a_b     <= epsc_pkg::THRESH_A_B_RST;
            cfg_reg.thresh_b_c     <= epsc_pkg::THRESH_B_C_RST;
            cfg_reg.thresh_c_d     <= epsc_pkg::THRESH_C_D_RST;
            cfg_reg.thresh_d_floor <= epsc_pkg::THRESH_D_FLOOR_RST;
            cfg_reg.thresh_diode   <= epsc_pkg::THRESH_DIODE_RST;
            cfg_reg.check_enables  <= epsc_pkg::CHECK_ENABLES_RST;
            cfg_reg.capacity_amps  <= epsc_pkg::CAPACITY_AMPS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                epsc_pkg::REG_THRESH_A_B:     cfg_reg.thresh_a_b     <= cfg_data;
                epsc_pkg::REG_THRESH_B_C:     cfg_reg.thresh_b_c     <= cfg_data;
                epsc_pkg::REG_THRESH_C_D:     cfg_reg.thresh_c_d     <= cfg_data;
                epsc_pkg::REG_THRESH_D_FLOOR: cfg_reg.thresh_d_floor <= cfg_data;
                epsc_pkg::REG_THRESH_DIODE:   cfg_reg.thresh_diode   <= cfg_data;
                epsc_pkg::REG_CHECK_ENABLES:  cfg_reg.check_enables  <= cfg_data[1:0];
                epsc_pkg::REG_CAPACITY_AMPS:  cfg_reg.capacity_amps  <= cfg_data[6:0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign evse_state    = cur_state_reg;
    assign state_changed = changed_reg;
    assign relay_on      = relay_reg;
    assign pilot_mode    = mode_reg;
    assign pwm_amps      = amps_reg;
    assign fault_flag    = fault_reg;

`ifndef SYNTH
    // a new debounced state is always the candidate held from the previous beat
    a_change_from_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cur_state_next != cur_state_reg)) |-> (cur_state_next == cand_state_reg))
        else $error("debounced state changed without a held candidate");

    // relay closes only in state C with PWM running
    a_relay_only_in_c: assert property (@(posedge clk) disable iff (!rst_n)
        relay_on |-> ((evse_state == epsc_pkg::ST_C) && (pilot_mode == epsc_pkg::MODE_PWM)))
        else $error("relay closed outside state C");

    // fault flag is clear exactly in states A, B and C
    a_fault_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        fault_flag == !((evse_state == epsc_pkg::ST_A) || (evse_state == epsc_pkg::ST_B)
                        || (evse_state == epsc_pkg::ST_C)))
        else $error("fault flag disagrees with state");

    // advertised current stays within the legal range while PWM runs
    a_pwm_amps_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pilot_mode == epsc_pkg::MODE_PWM)
        |-> ((pwm_amps >= epsc_pkg::AMPS_MIN) && (pwm_amps <= epsc_pkg::AMPS_MAX)))
        else $error("pwm amps out of range");

    // an empty input register never holds off the sender
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");
`endif

endmodule
